FILE: rtl/core/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  // distance format: unsigned Q16.16
  localparam int DIST_FRAC = 16;
  localparam int DIST_W    = 32;
  // barycentric quotient bits: values 0 .. 65536
  localparam int BARY_W    = 17;
  localparam logic [BARY_W:0] ONE_Q16 = 18'd65536;

  localparam int MIN_DIST_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index decoded from paddr[2]
  localparam logic REG_MIN_DISTANCE = 1'b0;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // control that travels beside a beat
  typedef struct packed {
    logic valid;
    logic miss;
  } ctl_t;

endpackage

FILE: rtl/core/rti_udiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_udiv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rti_udiv #(
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rti_pkg::ctl_t  in_ctl,
  input  logic [DW-1:0]  rem0,     // partial remainder, below dsr
  input  logic [QW-1:0]  low,      // dividend bits still to shift in, msb first
  input  logic [DW-1:0]  dsr,
  input  logic [SW-1:0]  side_in,
  output rti_pkg::ctl_t  out_ctl,
  output logic [QW-1:0]  quo,
  output logic [SW-1:0]  side_out
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] lo  [QW];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] qo  [QW];
  logic [SW-1:0] sd  [QW];
  logic          vl  [QW];
  logic          ms  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] c_rem;
    logic [QW-1:0] c_lo;
    logic [DW-1:0] c_dv;
    logic [QW-1:0] c_qo;
    logic [SW-1:0] c_sd;
    logic          c_vl;
    logic          c_ms;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign c_rem = rem0;
      assign c_lo  = low;
      assign c_dv  = dsr;
      assign c_qo  = '0;
      assign c_sd  = side_in;
      assign c_vl  = in_ctl.valid;
      assign c_ms  = in_ctl.miss;
    end else begin : g_next
      assign c_rem = rem[k-1];
      assign c_lo  = lo[k-1];
      assign c_dv  = dv[k-1];
      assign c_qo  = qo[k-1];
      assign c_sd  = sd[k-1];
      assign c_vl  = vl[k-1];
      assign c_ms  = ms[k-1];
    end

    assign trial = {c_rem, c_lo[QW-1]};
    assign diff  = trial - {1'b0, c_dv};
    assign ge    = trial >= {1'b0, c_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= c_vl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo[k]  <= {c_lo[QW-2:0], 1'b0};
        dv[k]  <= c_dv;
        qo[k]  <= {c_qo[QW-2:0], ge};
        sd[k]  <= c_sd;
        ms[k]  <= c_ms;
      end
    end
  end

  assign out_ctl.valid = vl[QW-1];
  assign out_ctl.miss  = ms[QW-1];
  assign quo           = qo[QW-1];
  assign side_out      = sd[QW-1];

endmodule

FILE: rtl/core/rti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_front
// Edges, normal, plane numerator/denominator, projection axis select.
// ----------------------------------------------------------------------------
module rti_front #(
  parameter int COORD_BITS = 16
) (
  clk, rst, en, in_valid, in_data,
  out_ctl, rem0, low, ud,
  wu, wv, du, dv, bu, bv, cu, cv, dvq
);

  localparam int CB   = COORD_BITS;
  localparam int D1   = CB + 1;
  localparam int NW   = 2 * D1 + 1;
  localparam int PW   = D1 + NW;
  localparam int NUMW = PW + 2;
  localparam int DNW  = CB + NW;
  localparam int DENW = DNW + 2;
  localparam int DVW  = 2 * D1 + 1;
  localparam int IN_W = 15 * CB;

  input  logic                  clk;
  input  logic                  rst;
  input  logic                  en;
  input  logic                  in_valid;
  input  logic [IN_W-1:0]       in_data;
  output rti_pkg::ctl_t         out_ctl;
  output logic [DENW-1:0]       rem0;
  output logic [rti_pkg::DIST_W-1:0] low;
  output logic [DENW-1:0]       ud;
  output logic signed [D1-1:0]  wu;
  output logic signed [D1-1:0]  wv;
  output logic signed [CB-1:0]  du;
  output logic signed [CB-1:0]  dv;
  output logic signed [D1-1:0]  bu;
  output logic signed [D1-1:0]  bv;
  output logic signed [D1-1:0]  cu;
  output logic signed [D1-1:0]  cv;
  output logic signed [DVW-1:0] dvq;

  // stage 1: edges and origin offset
  logic signed [CB-1:0] o0 [3], d0 [3], a0 [3], pb0 [3], pc0 [3];
  logic signed [D1-1:0] b1 [3], c1 [3], w1 [3];
  logic signed [CB-1:0] d1 [3];
  logic                 v1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o0[i]  = $signed(in_data[i*CB +: CB]);
      d0[i]  = $signed(in_data[(3+i)*CB +: CB]);
      a0[i]  = $signed(in_data[(6+i)*CB +: CB]);
      pb0[i] = $signed(in_data[(9+i)*CB +: CB]);
      pc0[i] = $signed(in_data[(12+i)*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b1[i] <= D1'(pc0[i]) - D1'(a0[i]);
        c1[i] <= D1'(pb0[i]) - D1'(a0[i]);
        w1[i] <= D1'(o0[i]) - D1'(a0[i]);
        d1[i] <= d0[i];
      end
    end
  end

  // stage 2: normal n = c x b
  logic signed [NW-1:0] n2 [3];
  logic signed [D1-1:0] b2 [3], c2 [3], w2 [3];
  logic signed [CB-1:0] d2 [3];
  logic                 v2;

  always_ff @(posedge clk) begin
    if (en) begin
      n2[0] <= NW'(c1[1] * b1[2]) - NW'(c1[2] * b1[1]);
      n2[1] <= NW'(c1[2] * b1[0]) - NW'(c1[0] * b1[2]);
      n2[2] <= NW'(c1[0] * b1[1]) - NW'(c1[1] * b1[0]);
      b2 <= b1;
      c2 <= c1;
      w2 <= w1;
      d2 <= d1;
    end
  end

  // stage 3: dot products, dominant axis and projection select
  logic [NW-1:0]          an [3];
  rti_pkg::axis_t         k3;
  logic signed [PW-1:0]   pw3 [3];
  logic signed [DNW-1:0]  pd3 [3];
  logic signed [D1-1:0]   wu3, wv3, bu3, bv3, cu3, cv3;
  logic signed [CB-1:0]   du3, dv3;
  logic signed [D1-1:0]   s_wu, s_wv, s_bu, s_bv, s_cu, s_cv;
  logic signed [CB-1:0]   s_du, s_dv;
  logic                   v3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an[i] = n2[i][NW-1] ? NW'(-n2[i]) : NW'(n2[i]);
    end
    if (an[0] > an[1]) begin
      k3 = (an[0] > an[2]) ? rti_pkg::AXIS_X : rti_pkg::AXIS_Z;
    end else begin
      k3 = (an[1] > an[2]) ? rti_pkg::AXIS_Y : rti_pkg::AXIS_Z;
    end
    // drop axis k, keep u = k+1 and v = k+2 (mod 3)
    case (k3)
      rti_pkg::AXIS_X: begin
        s_wu = w2[1]; s_wv = w2[2]; s_du = d2[1]; s_dv = d2[2];
        s_bu = b2[1]; s_bv = b2[2]; s_cu = c2[1]; s_cv = c2[2];
      end
      rti_pkg::AXIS_Y: begin
        s_wu = w2[2]; s_wv = w2[0]; s_du = d2[2]; s_dv = d2[0];
        s_bu = b2[2]; s_bv = b2[0]; s_cu = c2[2]; s_cv = c2[0];
      end
      default: begin
        s_wu = w2[0]; s_wv = w2[1]; s_du = d2[0]; s_dv = d2[1];
        s_bu = b2[0]; s_bv = b2[1]; s_cu = c2[0]; s_cv = c2[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pw3[i] <= PW'(w2[i]) * PW'(n2[i]);
        pd3[i] <= DNW'(d2[i]) * DNW'(n2[i]);
      end
      wu3 <= s_wu; wv3 <= s_wv; du3 <= s_du; dv3 <= s_dv;
      bu3 <= s_bu; bv3 <= s_bv; cu3 <= s_cu; cv3 <= s_cv;
    end
  end

  // stage 4: sums and projected determinant products
  logic signed [NUMW-1:0]  num4;
  logic signed [DENW-1:0]  den4;
  logic signed [2*D1-1:0]  pbc4, pbv4;
  logic signed [D1-1:0]    wu4, wv4, bu4, bv4, cu4, cv4;
  logic signed [CB-1:0]    du4, dv4;
  logic                    v4;

  always_ff @(posedge clk) begin
    if (en) begin
      num4 <= -(NUMW'(pw3[0]) + NUMW'(pw3[1]) + NUMW'(pw3[2]));
      den4 <= DENW'(pd3[0]) + DENW'(pd3[1]) + DENW'(pd3[2]);
      pbc4 <= (2*D1)'(bu3) * (2*D1)'(cv3);
      pbv4 <= (2*D1)'(bv3) * (2*D1)'(cu3);
      wu4 <= wu3; wv4 <= wv3; du4 <= du3; dv4 <= dv3;
      bu4 <= bu3; bv4 <= bv3; cu4 <= cu3; cv4 <= cv3;
    end
  end

  // stage 5: magnitudes, early miss, divider seed
  logic [NUMW-1:0] un5;
  logic [DENW-1:0] ud5;
  logic            miss5;

  always_comb begin
    un5 = num4[NUMW-1] ? NUMW'(-num4) : NUMW'(num4);
    ud5 = den4[DENW-1] ? DENW'(-den4) : DENW'(den4);
    // parallel plane, plane at origin, behind origin, t >= 65536 (beyond the Q16.16 range)
    miss5 = (den4 == '0) || (num4 == '0) || (num4[NUMW-1] != den4[DENW-1]) ||
            ({un5} >= {ud5, {rti_pkg::DIST_FRAC{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_ctl.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl.miss <= miss5;
      rem0 <= DENW'(un5 >> rti_pkg::DIST_FRAC);
      low  <= {un5[rti_pkg::DIST_FRAC-1:0], {rti_pkg::DIST_FRAC{1'b0}}};
      ud   <= ud5;
      dvq  <= DVW'(pbc4) - DVW'(pbv4);
      wu <= wu4; wv <= wv4; du <= du4; dv <= dv4;
      bu <= bu4; bv <= bv4; cu <= cu4; cv <= cv4;
    end
  end

endmodule

FILE: rtl/core/rti_mid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_mid
// Hit point on the projection plane, barycentric numerators, divider seeds.
// ----------------------------------------------------------------------------
module rti_mid #(
  parameter int COORD_BITS = 16
) (
  clk, rst, en, in_ctl, t, min_distance,
  wu, wv, du, dv, bu, bv, cu, cv, dvq,
  out_ctl, out_t, dv_zero, rem_b, low_b, rem_g, low_g, dvm
);

  localparam int CB   = COORD_BITS;
  localparam int D1   = CB + 1;
  localparam int DVW  = 2 * D1 + 1;
  localparam int TW   = rti_pkg::DIST_W + 1;
  localparam int PTW  = TW + CB;
  localparam int HWF  = CB + 34;
  localparam int HW   = CB + 18;
  localparam int PBW  = D1 + HW;
  localparam int BNW  = PBW + 1;
  localparam int QB   = rti_pkg::BARY_W;
  localparam int DV17 = DVW + QB;

  input  logic                         clk;
  input  logic                         rst;
  input  logic                         en;
  input  rti_pkg::ctl_t                in_ctl;
  input  logic [rti_pkg::DIST_W-1:0]   t;
  input  logic [rti_pkg::MIN_DIST_W-1:0] min_distance;
  input  logic signed [D1-1:0]         wu;
  input  logic signed [D1-1:0]         wv;
  input  logic signed [CB-1:0]         du;
  input  logic signed [CB-1:0]         dv;
  input  logic signed [D1-1:0]         bu;
  input  logic signed [D1-1:0]         bv;
  input  logic signed [D1-1:0]         cu;
  input  logic signed [D1-1:0]         cv;
  input  logic signed [DVW-1:0]        dvq;
  output rti_pkg::ctl_t                out_ctl;
  output logic [rti_pkg::DIST_W-1:0]   out_t;
  output logic                         dv_zero;
  output logic [DVW-1:0]               rem_b;
  output logic [QB-1:0]                low_b;
  output logic [DVW-1:0]               rem_g;
  output logic [QB-1:0]                low_g;
  output logic [DVW-1:0]               dvm;

  logic va, vb, vc, vd, ve, vf;

  // stage A: distance limit, t * d on u and v, |det|
  logic signed [TW-1:0]  ts;
  logic signed [PTW-1:0] ptu_a, ptv_a;
  logic [DVW-1:0]        dvm_a;
  logic                  miss_a, dz_a, dneg_a;
  logic [rti_pkg::DIST_W-1:0] t_a;
  logic signed [D1-1:0]  wu_a, wv_a, bu_a, bv_a, cu_a, cv_a;

  assign ts = $signed({1'b0, t});

  always_ff @(posedge clk) begin
    if (en) begin
      ptu_a  <= PTW'(ts) * PTW'(du);
      ptv_a  <= PTW'(ts) * PTW'(dv);
      dvm_a  <= dvq[DVW-1] ? DVW'(-dvq) : DVW'(dvq);
      dz_a   <= (dvq == '0);
      dneg_a <= dvq[DVW-1];
      miss_a <= in_ctl.miss || (t <= rti_pkg::DIST_W'(min_distance));
      t_a    <= t;
      wu_a <= wu; wv_a <= wv; bu_a <= bu; bv_a <= bv; cu_a <= cu; cv_a <= cv;
    end
  end

  // stage B: hit point relative to vertex A, and 65537 * |det|
  logic signed [HWF-1:0] hu_b, hv_b;
  logic [DV17-1:0]       dvbig_b;
  logic [DVW-1:0]        dvm_b;
  logic                  miss_b, dz_b, dneg_b;
  logic [rti_pkg::DIST_W-1:0] t_b;
  logic signed [D1-1:0]  bu_b, bv_b, cu_b, cv_b;

  always_ff @(posedge clk) begin
    if (en) begin
      hu_b <= (HWF'(wu_a) <<< rti_pkg::DIST_FRAC) + HWF'(ptu_a);
      hv_b <= (HWF'(wv_a) <<< rti_pkg::DIST_FRAC) + HWF'(ptv_a);
      dvbig_b <= {dvm_a, {(QB-1){1'b0}}} + DV17'(dvm_a);
      dvm_b  <= dvm_a;
      miss_b <= miss_a;
      dz_b   <= dz_a;
      dneg_b <= dneg_a;
      t_b    <= t_a;
      bu_b <= bu_a; bv_b <= bv_a; cu_b <= cu_a; cv_b <= cv_a;
    end
  end

  // stage C: far point check, narrow the hit point
  logic [HWF-1:0]        ahu, ahv;
  logic signed [HW-1:0]  hu_c, hv_c;
  logic [DV17-1:0]       dvbig_c;
  logic [DVW-1:0]        dvm_c;
  logic                  miss_c, dz_c, dneg_c;
  logic [rti_pkg::DIST_W-1:0] t_c;
  logic signed [D1-1:0]  bu_c, bv_c, cu_c, cv_c;

  always_comb begin
    ahu = hu_b[HWF-1] ? HWF'(-hu_b) : HWF'(hu_b);
    ahv = hv_b[HWF-1] ? HWF'(-hv_b) : HWF'(hv_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hu_c <= hu_b[HW-1:0];
      hv_c <= hv_b[HW-1:0];
      miss_c <= miss_b || (|ahu[HWF-1:CB+17]) || (|ahv[HWF-1:CB+17]);
      dvbig_c <= dvbig_b;
      dvm_c <= dvm_b;
      dz_c  <= dz_b;
      dneg_c <= dneg_b;
      t_c   <= t_b;
      bu_c <= bu_b; bv_c <= bv_b; cu_c <= cu_b; cv_c <= cv_b;
    end
  end

  // stage D: barycentric products
  logic signed [PBW-1:0] p0_d, p1_d, p2_d, p3_d;
  logic [DV17-1:0]       dvbig_d;
  logic [DVW-1:0]        dvm_d;
  logic                  miss_d, dz_d, dneg_d;
  logic [rti_pkg::DIST_W-1:0] t_d;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_d <= PBW'(bu_c) * PBW'(hv_c);
      p1_d <= PBW'(bv_c) * PBW'(hu_c);
      p2_d <= PBW'(cv_c) * PBW'(hu_c);
      p3_d <= PBW'(cu_c) * PBW'(hv_c);
      dneg_d <= dneg_c;
      dvbig_d <= dvbig_c;
      dvm_d  <= dvm_c;
      miss_d <= miss_c;
      dz_d   <= dz_c;
      t_d    <= t_c;
    end
  end

  // stage E: numerators
  logic signed [BNW-1:0] bn_e, gn_e;
  logic [DV17-1:0]       dvbig_e;
  logic [DVW-1:0]        dvm_e;
  logic                  miss_e, dz_e, dneg_e;
  logic [rti_pkg::DIST_W-1:0] t_e;

  always_ff @(posedge clk) begin
    if (en) begin
      bn_e <= BNW'(p0_d) - BNW'(p1_d);
      gn_e <= BNW'(p2_d) - BNW'(p3_d);
      dvbig_e <= dvbig_d;
      dvm_e  <= dvm_d;
      miss_e <= miss_d;
      dz_e   <= dz_d;
      dneg_e <= dneg_d;
      t_e    <= t_d;
    end
  end

  // stage F: magnitudes; quotient sign differs from numerator when det < 0
  logic [BNW-1:0]  abn_f, agn_f;
  logic            bdiff_f, gdiff_f;
  logic [DV17-1:0] dvbig_f;
  logic [DVW-1:0]  dvm_f;
  logic            miss_f, dz_f;
  logic [rti_pkg::DIST_W-1:0] t_f;
  logic            dsgn;

  // determinant sign, carried beside |det| since stage A
  assign dsgn = dneg_e;

  always_ff @(posedge clk) begin
    if (en) begin
      abn_f <= bn_e[BNW-1] ? BNW'(-bn_e) : BNW'(bn_e);
      agn_f <= gn_e[BNW-1] ? BNW'(-gn_e) : BNW'(gn_e);
      bdiff_f <= bn_e[BNW-1] ^ dsgn;
      gdiff_f <= gn_e[BNW-1] ^ dsgn;
      dvbig_f <= dvbig_e;
      dvm_f  <= dvm_e;
      miss_f <= miss_e;
      dz_f   <= dz_e;
      t_f    <= t_e;
    end
  end

  // stage G: negative or oversized quotients, divider seeds
  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl.miss <= miss_f ||
                      (bdiff_f && (BNW'(dvm_f) <= abn_f)) ||
                      (gdiff_f && (BNW'(dvm_f) <= agn_f)) ||
                      ({abn_f} >= {dvbig_f}) || ({agn_f} >= {dvbig_f});
      rem_b   <= DVW'(abn_f >> QB);
      low_b   <= abn_f[QB-1:0];
      rem_g   <= DVW'(agn_f >> QB);
      low_g   <= agn_f[QB-1:0];
      dvm     <= dvm_f;
      dv_zero <= dz_f;
      out_t   <= t_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else if (en) begin
      va <= in_ctl.valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      out_ctl.valid <= vf;
    end
  end

endmodule

FILE: rtl/core/ray_triangle_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Fixed-point ray / triangle hit test by the projection method.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A ray (origin, direction) and a triangle, all
// signed Q8.8, give hit and distance t in unsigned Q16.16, truncated toward
// zero. Unless the result side stalls, the block takes a new beat every cycle
// and holds one result per beat in order; each beat runs through the front,
// the distance divider (one quotient bit per stage), hit point and barycentric
// setup, the barycentric dividers and an output register. A result-side stall
// freezes the whole pipeline and drops s_tready. Misses (parallel ray, plane
// behind or at the origin, t >= 65536, t <= min_distance, degenerate
// projection, far hit point, barycentric test failed) give hit 0, distance 0.
// min_distance is at byte address 0; write it only while the pipeline is idle.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top #(
  parameter int COORD_BITS = 16
) (
  clk, rst,
  s_tvalid, s_tready, s_tdata,
  m_tvalid, m_tready, m_tdata, m_tuser,
  psel, penable, pwrite, paddr, pwdata, prdata, pready
);

  localparam int CB   = COORD_BITS;
  localparam int D1   = CB + 1;
  localparam int NW   = 2 * D1 + 1;
  localparam int DENW = CB + NW + 2;
  localparam int DVW  = 2 * D1 + 1;
  localparam int RAWW = 15 * CB;
  localparam int IN_W = ((RAWW + 7) / 8) * 8;
  localparam int SIDEW = 6 * D1 + 2 * CB + DVW;
  localparam int QB   = rti_pkg::BARY_W;

  input  logic clk;
  input  logic rst;

  input  logic             s_tvalid;
  output logic             s_tready;
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
  // vertex_a, vertex_b, vertex_c (lowest first), zero fill to bytes
  input  logic [IN_W-1:0]  s_tdata;

  output logic                        m_tvalid;
  input  logic                        m_tready;
  output logic [rti_pkg::DIST_W-1:0]  m_tdata;   // distance
  output logic                        m_tuser;   // hit

  input  logic                          psel;
  input  logic                          penable;
  input  logic                          pwrite;
  input  logic [rti_pkg::CFG_ADDR_W-1:0] paddr;
  input  logic [rti_pkg::CFG_DATA_W-1:0] pwdata;
  output logic [rti_pkg::CFG_DATA_W-1:0] prdata;
  output logic                          pready;

  // config register
  logic [rti_pkg::MIN_DIST_W-1:0] min_distance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rti_pkg::REG_MIN_DISTANCE) ?
                  rti_pkg::CFG_DATA_W'(min_distance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= rti_pkg::MIN_DIST_W'(65);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rti_pkg::REG_MIN_DISTANCE)) begin
      min_distance <= pwdata[rti_pkg::MIN_DIST_W-1:0];
    end
  end

  // global advance: everything moves unless a held result is not taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front end: normal, plane terms, axis select
  rti_pkg::ctl_t         f_ctl;
  logic [DENW-1:0]       f_rem0, f_ud;
  logic [rti_pkg::DIST_W-1:0] f_low;
  logic signed [D1-1:0]  f_wu, f_wv, f_bu, f_bv, f_cu, f_cv;
  logic signed [CB-1:0]  f_du, f_dv;
  logic signed [DVW-1:0] f_dvq;

  rti_front #(.COORD_BITS(CB)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && s_tready),
    .in_data(s_tdata[RAWW-1:0]),
    .out_ctl(f_ctl), .rem0(f_rem0), .low(f_low), .ud(f_ud),
    .wu(f_wu), .wv(f_wv), .du(f_du), .dv(f_dv),
    .bu(f_bu), .bv(f_bv), .cu(f_cu), .cv(f_cv), .dvq(f_dvq)
  );

  // distance divider: T = floor(|num| * 2^16 / |den|)
  logic [SIDEW-1:0]      t_side_in, t_side;
  rti_pkg::ctl_t         t_ctl;
  logic [rti_pkg::DIST_W-1:0] t_quo;

  assign t_side_in = {f_wu, f_wv, f_du, f_dv, f_bu, f_bv, f_cu, f_cv, f_dvq};

  rti_udiv #(.DW(DENW), .QW(rti_pkg::DIST_W), .SW(SIDEW)) u_tdiv (
    .clk(clk), .rst(rst), .en(en), .in_ctl(f_ctl),
    .rem0(f_rem0), .low(f_low), .dsr(f_ud), .side_in(t_side_in),
    .out_ctl(t_ctl), .quo(t_quo), .side_out(t_side)
  );

  logic signed [D1-1:0]  m_wu, m_wv, m_bu, m_bv, m_cu, m_cv;
  logic signed [CB-1:0]  m_du, m_dv;
  logic signed [DVW-1:0] m_dvq;

  assign {m_wu, m_wv, m_du, m_dv, m_bu, m_bv, m_cu, m_cv, m_dvq} = t_side;

  // hit point and barycentric numerators
  rti_pkg::ctl_t         h_ctl;
  logic [rti_pkg::DIST_W-1:0] h_t;
  logic                  h_dz;
  logic [DVW-1:0]        h_rem_b, h_rem_g, h_dvm;
  logic [QB-1:0]         h_low_b, h_low_g;

  rti_mid #(.COORD_BITS(CB)) u_mid (
    .clk(clk), .rst(rst), .en(en), .in_ctl(t_ctl), .t(t_quo),
    .min_distance(min_distance),
    .wu(m_wu), .wv(m_wv), .du(m_du), .dv(m_dv),
    .bu(m_bu), .bv(m_bv), .cu(m_cu), .cv(m_cv), .dvq(m_dvq),
    .out_ctl(h_ctl), .out_t(h_t), .dv_zero(h_dz),
    .rem_b(h_rem_b), .low_b(h_low_b), .rem_g(h_rem_g), .low_g(h_low_g),
    .dvm(h_dvm)
  );

  // beta and gamma dividers run side by side
  rti_pkg::ctl_t         b_ctl, g_ctl;
  logic [QB-1:0]         beta, gamma;
  logic [rti_pkg::DIST_W-1:0] b_t;
  logic                  g_dz;

  rti_udiv #(.DW(DVW), .QW(QB), .SW(rti_pkg::DIST_W)) u_bdiv (
    .clk(clk), .rst(rst), .en(en), .in_ctl(h_ctl),
    .rem0(h_rem_b), .low(h_low_b), .dsr(h_dvm), .side_in(h_t),
    .out_ctl(b_ctl), .quo(beta), .side_out(b_t)
  );

  rti_udiv #(.DW(DVW), .QW(QB), .SW(1)) u_gdiv (
    .clk(clk), .rst(rst), .en(en), .in_ctl(h_ctl),
    .rem0(h_rem_g), .low(h_low_g), .dsr(h_dvm), .side_in(h_dz),
    .out_ctl(g_ctl), .quo(gamma), .side_out(g_dz)
  );

  // final accept: beta + gamma <= 1.0
  logic [QB:0] bg_sum;
  logic        hit_now;

  assign bg_sum  = {1'b0, beta} + {1'b0, gamma};
  assign hit_now = !b_ctl.miss && !g_ctl.miss && !g_dz &&
                   (bg_sum <= rti_pkg::ONE_Q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= b_ctl.valid && g_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= hit_now;
      m_tdata <= hit_now ? b_t : '0;
    end
  end

endmodule

FILE: verif/ray_triangle_intersect_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top_test
// Self-checking bench for the fixed-point ray / triangle hit test.
// ----------------------------------------------------------------------------
// A queue of ray/triangle beats feeds a clocked driver; a clocked monitor
// predicts hit and distance for every accepted beat and compares each result
// beat in order. Directed corner cases come first, then mostly constructed
// hits with random content plus raw noise, over several min_distance values.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top_test;

  localparam int IN_W       = 240;
  localparam int LATENCY    = 62;
  localparam int STALL_LIM  = 3000;

  typedef struct packed {
    logic        hit;
    logic [31:0] dist_q;
  } hit_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // origin x,y,z; direction x,y,z (16b each); vertex a,b,c (48b each)
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // distance (32b)
  logic [31:0]       m_tdata;
  // hit (1b)
  logic              m_tuser;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rti_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [rti_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [rti_pkg::CFG_DATA_W-1:0] prdata;
  logic              pready;

  ray_triangle_intersect_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  logic [IN_W-1:0] pending_rays[$];
  hit_res_t        expected_hits[$];
  logic [15:0]     min_dist = 16'd65;
  bit              calm = 0;        // no idling on either side
  int              errors = 0;
  int              n_results = 0, n_hits = 0;
  logic            in_fire = 0, out_fire = 0;

  // ---------------------------------------------------------------- predictor
  function automatic hit_res_t predict_hit(logic [IN_W-1:0] bt, logic [15:0] mind);
    longint o[3], d[3], a[3], pb[3], pc[3], b[3], c[3], n[3], w[3];
    longint num, den, hu, hv, bu, bv, cu, cv, dv, bn, gn, beta, gam;
    longint unsigned un, ud, q, r, f, t;
    rti_pkg::axis_t k;
    int     u, v;
    hit_res_t res;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      o[i]  = longint'($signed(bt[16*i +: 16]));
      d[i]  = longint'($signed(bt[48 + 16*i +: 16]));
      a[i]  = longint'($signed(bt[96 + 16*i +: 16]));
      pb[i] = longint'($signed(bt[144 + 16*i +: 16]));
      pc[i] = longint'($signed(bt[192 + 16*i +: 16]));
    end
    for (int i = 0; i < 3; i++) begin
      b[i] = pc[i] - a[i];
      c[i] = pb[i] - a[i];
      w[i] = o[i] - a[i];
    end
    n[0] = c[1]*b[2] - c[2]*b[1];
    n[1] = c[2]*b[0] - c[0]*b[2];
    n[2] = c[0]*b[1] - c[1]*b[0];
    num = -(w[0]*n[0] + w[1]*n[1] + w[2]*n[2]);
    den = d[0]*n[0] + d[1]*n[1] + d[2]*n[2];
    if (den == 0 || num == 0) return res;
    if ((num < 0) != (den < 0)) return res;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = un / ud;
    if (q >= 64'd65536) return res;
    r = un % ud;
    f = 0;
    // fraction bits by restoring division, avoids 64-bit overflow
    for (int i = 0; i < rti_pkg::DIST_FRAC; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= ud) begin
        r = r - ud;
        f = f | 1;
      end
    end
    t = (q << rti_pkg::DIST_FRAC) | f;
    if (t <= mind) return res;
    // dominant axis: strict wins only; an x/y tie goes to y, a tie with z goes to z
    for (int i = 0; i < 3; i++) if (n[i] < 0) n[i] = -n[i];
    if (n[0] > n[1]) k = (n[0] > n[2]) ? rti_pkg::AXIS_X : rti_pkg::AXIS_Z;
    else             k = (n[1] > n[2]) ? rti_pkg::AXIS_Y : rti_pkg::AXIS_Z;
    u = (int'(k) + 1) % 3;
    v = (int'(k) + 2) % 3;
    hu = w[u]*65536 + longint'(t)*d[u];
    hv = w[v]*65536 + longint'(t)*d[v];
    if (hu >= 64'sd8589934592 || -hu >= 64'sd8589934592) return res;
    if (hv >= 64'sd8589934592 || -hv >= 64'sd8589934592) return res;
    bu = b[u]; bv = b[v]; cu = c[u]; cv = c[v];
    dv = bu*cv - bv*cu;
    if (dv == 0) return res;
    bn = bu*hv - bv*hu;
    beta = bn / dv;
    if (beta < 0) return res;
    gn = cv*hu - cu*hv;
    gam = gn / dv;
    if (gam < 0 || beta + gam > 65536) return res;
    res.hit    = 1'b1;
    res.dist_q = t[31:0];
    return res;
  endfunction

  // --------------------------------------------------------------- beat build
  function automatic logic [IN_W-1:0] pack_ray(int ox, int oy, int oz, int dx, int dy,
      int dz, int ax, int ay, int az, int bx, int by, int bz, int cx, int cy, int cz);
    logic [15:0] f[15];
    f = '{ox[15:0], oy[15:0], oz[15:0], dx[15:0], dy[15:0], dz[15:0],
          ax[15:0], ay[15:0], az[15:0], bx[15:0], by[15:0], bz[15:0],
          cx[15:0], cy[15:0], cz[15:0]};
    pack_ray = '0;
    for (int i = 0; i < 15; i++) pack_ray[16*i +: 16] = f[i];
  endfunction

  function automatic int srand_int(int lim);
    return $urandom_range(2*lim) - lim;
  endfunction

  // ray aimed at a point inside (or just outside) a random triangle
  function automatic logic [IN_W-1:0] aimed_ray();
    int vtx[9], o[3], p[3], dd[3], r1, r2, s, lim;
    lim = ($urandom_range(3) == 0) ? 12000 : 3000;
    for (int i = 0; i < 9; i++) vtx[i] = srand_int(lim);
    for (int i = 0; i < 3; i++) o[i] = srand_int(lim);
    r1 = $urandom_range(1100);
    r2 = $urandom_range(1100 - ((r1 > 1100) ? 1100 : r1));
    s  = $urandom_range(1, 6);
    for (int i = 0; i < 3; i++) begin
      p[i]  = vtx[i] + (r1*(vtx[3+i] - vtx[i]) + r2*(vtx[6+i] - vtx[i])) / 1024;
      dd[i] = (p[i] - o[i]) / s;
      if (dd[i] > 32767) dd[i] = 32767;
      if (dd[i] < -32768) dd[i] = -32768;
    end
    return pack_ray(o[0], o[1], o[2], dd[0], dd[1], dd[2], vtx[0], vtx[1], vtx[2],
                    vtx[3], vtx[4], vtx[5], vtx[6], vtx[7], vtx[8]);
  endfunction

  function automatic logic [IN_W-1:0] noise_ray();
    logic [IN_W-1:0] x;
    for (int i = 0; i < IN_W/16; i++)
      x[16*i +: 16] = ($urandom_range(1) == 0) ? 16'($urandom()) : 16'(srand_int(64));
    return x;
  endfunction

  // ------------------------------------------------------------------ driver
  int in_gap = 0;
  always @(negedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (rst) nv = 1'b0;
    else begin
      if (s_tvalid && in_fire) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_rays.size() > 0) begin
          s_tdata <= pending_rays.pop_front();
          nv = 1'b1;
          in_gap <= calm ? 0 : $urandom_range(6);
        end
      end
    end
    s_tvalid <= nv;
  end

  // receiver: a random wait per beat, plus one long hold once the run is underway
  int  out_wait = 0;
  int  long_hold = 0;
  bit  hold_done = 0;
  always @(negedge clk) begin
    int wt;
    if (!rst) begin
      if (!hold_done && n_results == 150) begin
        hold_done <= 1;
        long_hold <= 400;
        m_tready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        m_tready <= 1'b0;
      end else if (out_fire) begin
        wt = calm ? 0 : $urandom_range(6);
        m_tready <= (wt == 0);
        out_wait <= wt;
      end else if (!m_tready) begin
        if (out_wait > 0) out_wait <= out_wait - 1;
        m_tready <= (out_wait <= 1);
      end
    end
  end

  // ------------------------------------------------------- monitor + checker
  int quiet = 0;
  always @(posedge clk) begin
    hit_res_t exp_r;
    in_fire  <= s_tvalid && s_tready && !rst;
    out_fire <= m_tvalid && m_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results <= n_results + 1;
        if (m_tuser) n_hits <= n_hits + 1;
        if (expected_hits.size() == 0) begin
          $display("%0t: result beat with nothing expected: hit %0b dist %08h",
                   $time, m_tuser, m_tdata);
          errors = errors + 1;
        end else begin
          exp_r = expected_hits.pop_front();
          if (exp_r.hit !== m_tuser) begin
            $display("%0t: hit mismatch: expected %0b actual %0b", $time, exp_r.hit, m_tuser);
            errors = errors + 1;
          end
          if (exp_r.dist_q !== m_tdata) begin
            $display("%0t: distance mismatch: expected %08h actual %08h",
                     $time, exp_r.dist_q, m_tdata);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) expected_hits.push_back(predict_hit(s_tdata, min_dist));
      // watchdog on handshake progress
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else if (s_tvalid || expected_hits.size() > 0) begin
        quiet <= quiet + 1;
        if (quiet >= STALL_LIM) begin
          $display("%0t: timeout, no progress", $time);
          $display("ray_triangle_intersect_top_test failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  task automatic write_min_dist(logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, val}; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    min_dist = val;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_rays.size() > 0 || s_tvalid || expected_hits.size() > 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic random_batch(int count);
    for (int i = 0; i < count; i++)
      pending_rays.push_back(($urandom_range(9) < 7) ? aimed_ray() : noise_ray());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed corners at reset min_distance
    pending_rays.push_back('0);                                      // degenerate, den 0
    pending_rays.push_back({IN_W/16{16'h7fff}});
    pending_rays.push_back({IN_W/16{16'h8000}});
    pending_rays.push_back({IN_W/16{16'hffff}});
    // triangle in z=0 plane, ray straight down through an inner point: hit, t=1
    pending_rays.push_back(pack_ray(64, 64, 256, 0, 0, -256, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // same ray pointing away: plane behind
    pending_rays.push_back(pack_ray(64, 64, 256, 0, 0, 256, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // origin on the plane
    pending_rays.push_back(pack_ray(64, 64, 0, 0, 0, -256, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // parallel to plane
    pending_rays.push_back(pack_ray(64, 64, 256, 256, 0, 0, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // tiny direction, large distance: t = 32000, still in range
    pending_rays.push_back(pack_ray(64, 64, 32000, 0, 0, -1, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // huge direction, distance below min_distance
    pending_rays.push_back(pack_ray(64, 64, 1, 0, 0, -32768, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // just above min_distance: t = 33/32768, raw Q16.16 value 66
    pending_rays.push_back(pack_ray(64, 64, 33, 0, 0, -32768, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // outside the triangle
    pending_rays.push_back(pack_ray(600, 600, 256, 0, 0, -256, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // on the hypotenuse and at a vertex
    pending_rays.push_back(pack_ray(256, 256, 256, 0, 0, -256, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    pending_rays.push_back(pack_ray(0, 0, 256, 0, 0, -256, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    // collinear vertices
    pending_rays.push_back(pack_ray(64, 64, 256, 3, 5, -256, 0, 0, 0, 256, 256, 256,
                                    512, 512, 512));
    // normal ties: |nx|=|ny|, and all three equal
    pending_rays.push_back(pack_ray(512, 0, 0, -256, -256, 0, 256, 0, 0, 0, 256, 0,
                                    256, 0, 256));
    pending_rays.push_back(pack_ray(600, 600, 600, -256, -256, -256, 256, 0, 0,
                                    0, 256, 0, 0, 0, 256));
    // triangle in a vertical plane: drop x, then y
    pending_rays.push_back(pack_ray(256, 64, 64, -256, 0, 0, 0, 0, 0, 0, 512, 0, 0, 0, 512));
    pending_rays.push_back(pack_ray(64, 256, 64, 0, -256, 0, 0, 0, 0, 512, 0, 0, 0, 0, 512));
    // far hit point, large origin
    pending_rays.push_back(pack_ray(32767, 32767, 32767, -32768, -32768, -32768,
                                    -32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    drain();

    write_min_dist(16'd0);
    pending_rays.push_back(pack_ray(64, 64, 1, 0, 0, -32768, 0, 0, 0, 512, 0, 0, 0, 512, 0));
    random_batch(150);
    drain();

    write_min_dist(16'hffff);
    random_batch(150);
    drain();

    write_min_dist(16'($urandom()));
    calm = 1;
    random_batch(100);
    drain();
    calm = 0;

    write_min_dist(16'd65);
    random_batch(250);
    drain();

    $display("%0d rays checked, %0d hits, over 5 min_distance settings incl. 0 and 65535",
             n_results, n_hits);
    if (errors == 0) $display("ray_triangle_intersect_top_test passed");
    else $display("ray_triangle_intersect_top_test failed");
    $finish;
  end

endmodule

FILE: ray_triangle_intersect_top.f
rtl/core/rti_pkg.sv
rtl/core/rti_udiv.sv
rtl/core/rti_front.sv
rtl/core/rti_mid.sv
rtl/core/ray_triangle_intersect_top.sv
verif/ray_triangle_intersect_top_test.sv
